/* rtl/core/ddvp_pkg.sv */
// Shared types and constants for the delta-of-delta varint packer.
package ddvp_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] ResetMark = 8'h01;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_SELECT,
    S_MARK,
    S_WORD,
    S_VALUE
  } ddvp_state_e;

  typedef struct packed {
    logic capture;
    logic calc;
    logic select;
    logic emit_mark;
    logic emit_word;
    logic emit_value;
  } ddvp_cmd_t;

  typedef struct packed {
    logic use_reset;
    logic more;
    logic room;
  } ddvp_status_t;

endpackage

/* rtl/core/ddvp_ctrl.sv */
// Sequencing state machine of the delta-of-delta varint packer.
module ddvp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ddvp_pkg::ddvp_status_t status_i,
  output ddvp_pkg::ddvp_cmd_t    cmd_o
);
  import ddvp_pkg::*;

  ddvp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DELTA;
      end
      S_DELTA: begin
        state_d = S_SELECT;
      end
      S_SELECT: begin
        state_d = status_i.use_reset ? S_MARK : S_WORD;
      end
      S_MARK: begin
        if (status_i.room) state_d = S_WORD;
      end
      S_WORD: begin
        if (status_i.room && !status_i.more) state_d = S_VALUE;
      end
      S_VALUE: begin
        if (status_i.room && !status_i.more) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_DELTA:  cmd_o.calc       = 1'b1;
      S_SELECT: cmd_o.select     = 1'b1;
      S_MARK:   cmd_o.emit_mark  = status_i.room;
      S_WORD:   cmd_o.emit_word  = status_i.room;
      S_VALUE:  cmd_o.emit_value = status_i.room;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* rtl/core/ddvp_dp.sv */
// Datapath: delta arithmetic, varint byte slicing and output register.
module ddvp_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic signed [ddvp_pkg::WordW-1:0] stamp_i,
  input  logic signed [ddvp_pkg::WordW-1:0] sample_value_i,
  input  ddvp_pkg::ddvp_cmd_t               cmd_i,
  output ddvp_pkg::ddvp_status_t            status_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ddvp_pkg::ByteW-1:0]       out_byte_o,
  output logic                            last_byte_o
);
  import ddvp_pkg::*;

  logic [WordW-1:0] last_stamp_q, last_delta_q;
  logic [WordW-1:0] stamp_q, value_q, delta_q, ddelta_q;
  logic             ov1_q, reset_q;
  logic [WordW-1:0] mag_q;
  logic             sign_q, first_q;
  logic             out_valid_q, last_q;
  logic [ByteW-1:0] out_byte_q;

  logic [WordW-1:0] delta_d, ddelta_d, word, value_mag;
  logic             ov1_d, ov2_d, reset_d, more;
  logic [ByteW-1:0] vbyte;
  logic             room, emit;

  assign delta_d  = stamp_i - last_stamp_q;
  assign ov1_d    = (stamp_i[WordW-1] ^ last_stamp_q[WordW-1]) &
                    (stamp_i[WordW-1] ^ delta_d[WordW-1]);
  assign ddelta_d = delta_q - last_delta_q;
  assign ov2_d    = (delta_q[WordW-1] ^ last_delta_q[WordW-1]) &
                    (delta_q[WordW-1] ^ ddelta_d[WordW-1]);
  assign reset_d  = ov1_q | ov2_d;

  assign word      = reset_q ? stamp_q : ddelta_q;
  assign value_mag = value_q[WordW-1] ? (WordW'(0) - value_q) : value_q;

  always_comb begin
    if (first_q) begin
      more  = |mag_q[WordW-1:6];
      vbyte = {more, mag_q[5:0], sign_q};
    end else begin
      more  = |mag_q[WordW-1:7];
      vbyte = {more, mag_q[6:0]};
    end
  end

  assign room = !out_valid_q || !out_stall_i;
  assign emit = cmd_i.emit_mark | cmd_i.emit_word | cmd_i.emit_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
      last_delta_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) last_stamp_q <= stamp_i;
      if (cmd_i.calc) last_delta_q <= reset_d ? stamp_q : delta_q;
      if (room) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      stamp_q <= stamp_i;
      value_q <= sample_value_i;
      delta_q <= delta_d;
      ov1_q   <= ov1_d;
    end
    if (cmd_i.calc) begin
      ddelta_q <= ddelta_d;
      reset_q  <= reset_d;
    end
    if (cmd_i.select) begin
      sign_q  <= word[WordW-1];
      mag_q   <= word[WordW-1] ? (WordW'(0) - word) : word;
      first_q <= 1'b1;
    end else if (cmd_i.emit_word && !more) begin
      sign_q  <= value_q[WordW-1];
      mag_q   <= value_mag;
      first_q <= 1'b1;
    end else if (cmd_i.emit_word || cmd_i.emit_value) begin
      mag_q   <= first_q ? (mag_q >> 6) : (mag_q >> 7);
      first_q <= 1'b0;
    end
    if (room && emit) begin
      out_byte_q <= cmd_i.emit_mark ? ResetMark : vbyte;
      last_q     <= cmd_i.emit_value && !more;
    end
  end

  assign status_o.use_reset = reset_q;
  assign status_o.more      = more;
  assign status_o.room      = room;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = last_q;

endmodule

/* rtl/core/delta_of_delta_varint_packer_core.sv */
// After acceptance the DELTA and SELECT states run before the first byte is registered,
// then one byte a cycle while the output is not stalled. Pairs are handled one at a time,
// paced by the single byte slicer and the two-step subtract before it.
// The next pair is taken once the final byte sits in the output register.
// Reset: asynchronous, active low; clears previous stamp and delta to zero
// and empties the output register.
// Top level of the delta-of-delta varint packer.
module delta_of_delta_varint_packer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ddvp_pkg::WordW-1:0] stamp_i,
  input  logic signed [ddvp_pkg::WordW-1:0] sample_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ddvp_pkg::ByteW-1:0]       out_byte_o,
  output logic                            last_byte_o
);
  import ddvp_pkg::*;

  ddvp_cmd_t    cmd;
  ddvp_status_t status;

  ddvp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ddvp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stamp_i        (stamp_i),
    .sample_value_i (sample_value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_byte_o    (last_byte_o)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a transaction while busy");

  a_accept_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (!out_valid_o || last_byte_o))
    else $error("new transaction before final byte of previous one");

  a_no_emit_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && !out_valid_o) |=> !out_valid_o)
    else $error("byte produced without a transaction");
`endif

endmodule

/* tb/sv/delta_of_delta_varint_packer_core_test.sv */
// Self-checking testbench for the delta-of-delta varint packer core.
`timescale 1ns / 100ps

module delta_of_delta_varint_packer_core_test;

  import ddvp_pkg::*;

  localparam logic [ByteW-1:0] ContBit = 8'h80;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandPairs = 140;
  localparam int unsigned DirPairs = 20;
  localparam int unsigned DrainCycles = 20;

  localparam logic [WordW-1:0] DirStamp [DirPairs] = '{
    32'h0000_0000, 32'h0000_000A, 32'h0000_0014, 32'h0000_001E, 32'h0000_0028,
    32'h0000_0032, 32'h0000_003D, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
    32'h0000_0000, 32'h4000_0000, 32'hF000_0000, 32'h0000_0000, 32'h0000_0001,
    32'h0000_0003, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE
  };
  localparam logic [WordW-1:0] DirValue [DirPairs] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_003F, 32'h0000_0040,
    32'hFFFF_FFC0, 32'h0000_1FFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
    32'hFFFF_E000, 32'h0000_0001, 32'h0000_0002, 32'h0000_3FFF, 32'hFFFF_FFFF,
    32'h7FFF_FFC0, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_0080, 32'h0000_2000
  };

  class ddvp_stream_model;
    typedef struct packed {
      logic [ByteW-1:0] data;
      logic             fin;
    } coded_byte_t;

    coded_byte_t      byte_queue[$];
    logic [WordW-1:0] prev_stamp;
    logic [WordW-1:0] chain_delta;
    int unsigned      pairs;
    int unsigned      bytes_seen;
    int unsigned      resyncs;
    int unsigned      errors;

    function new();
      prev_stamp  = '0;
      chain_delta = '0;
      pairs       = 0;
      bytes_seen  = 0;
      resyncs     = 0;
      errors      = 0;
    endfunction

    function int unsigned pending();
      return byte_queue.size();
    endfunction

    function bit sub_overflows(logic [WordW-1:0] a, logic [WordW-1:0] b,
                               logic [WordW-1:0] diff);
      return ((a ^ b) & (a ^ diff)) >> (WordW - 1) != 0;
    endfunction

    function void push_byte(logic [ByteW-1:0] data, logic fin);
      coded_byte_t e;
      e.data = data;
      e.fin  = fin;
      byte_queue.push_back(e);
    endfunction

    function void push_varint(logic [WordW-1:0] word, logic fin);
      logic [WordW-1:0] mag;
      logic [ByteW-1:0] b;
      mag = word[WordW-1] ? (32'd0 - word) : word;
      b = {1'b0, mag[5:0], word[WordW-1]};
      mag = mag >> 6;
      while (mag != 0) begin
        push_byte(b | ContBit, 1'b0);
        b = {1'b0, mag[6:0]};
        mag = mag >> 7;
      end
      push_byte(b, fin);
    endfunction

    function void take_pair(logic [WordW-1:0] stamp, logic [WordW-1:0] value);
      logic [WordW-1:0] delta;
      logic [WordW-1:0] ddelta;
      delta  = stamp - prev_stamp;
      ddelta = delta - chain_delta;
      if (!sub_overflows(stamp, prev_stamp, delta) &&
          !sub_overflows(delta, chain_delta, ddelta)) begin
        push_varint(ddelta, 1'b0);
      end else begin
        push_byte(ResetMark, 1'b0);
        delta = stamp;
        push_varint(stamp, 1'b0);
        resyncs++;
      end
      push_varint(value, 1'b1);
      prev_stamp  = stamp;
      chain_delta = delta;
      pairs++;
    endfunction

    function void check_byte(logic [ByteW-1:0] data, logic fin);
      coded_byte_t e;
      if (byte_queue.size() == 0) begin
        $error("out_byte: no byte expected, got %02h (last_byte %0b)", data, fin);
        errors++;
        return;
      end
      e = byte_queue.pop_front();
      bytes_seen++;
      if (data !== e.data) begin
        $error("out_byte: expected %02h, got %02h", e.data, data);
        errors++;
      end
      if (fin !== e.fin) begin
        $error("last_byte: expected %0b, got %0b", e.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [WordW-1:0] stamp = '0;
  logic [WordW-1:0] value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic             last_byte;

  ddvp_stream_model sb = new();
  bit               hold_req = 1'b0;
  int unsigned      idle_cycles = 0;
  int unsigned      burst_left = 0;

  delta_of_delta_varint_packer_core u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .stamp_i        (stamp),
    .sample_value_i (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .last_byte_o    (last_byte)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_byte(out_byte, last_byte);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("delta_of_delta_varint_packer_core: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stalls, bursts of free flow, and one long hold-off on request.
  initial begin
    int unsigned pick;
    int unsigned n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 6);
        end else if (pick < 85) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else if (pick < 93) begin
          out_stall <= 1'b1;
          n = $urandom_range(8, 40);
        end else begin
          out_stall <= 1'b0;
          n = $urandom_range(20, 80);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_pair(logic [WordW-1:0] ts, logic [WordW-1:0] val);
    in_valid <= 1'b1;
    stamp    <= ts;
    value    <= val;
    do @(posedge clk); while (in_stall);
    sb.take_pair(ts, val);
  endtask

  task automatic idle_input(int unsigned cycles);
    in_valid <= 1'b0;
    stamp    <= $urandom;
    value    <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
    end else if (pick < 5) begin
      burst_left = $urandom_range(15, 30);
    end else if (pick < 60) begin
    end else if (pick < 90) begin
      idle_input($urandom_range(1, 3));
    end else begin
      idle_input($urandom_range(8, 30));
    end
  endtask

  task automatic drain_output();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [WordW-1:0] rand_word();
    logic [WordW-1:0] w;
    int unsigned      bits;
    bits = $urandom_range(0, WordW);
    w = $urandom;
    w = w >> (WordW - bits);
    if ($urandom_range(0, 1) == 1) w = 32'd0 - w;
    return w;
  endfunction

  initial begin
    logic [WordW-1:0] ts;
    logic [WordW-1:0] cur_stamp;
    logic [WordW-1:0] period;
    int unsigned      pick;
    int               jitter;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirPairs; i++) begin
      send_pair(DirStamp[i], DirValue[i]);
      random_gap();
    end
    cur_stamp = DirStamp[DirPairs-1];
    period = 32'd1000;

    for (int i = 0; i < RandPairs; i++) begin
      if (i == 40) hold_req = 1'b1;
      if (i == 100) begin
        idle_input(1);
        drain_output();
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 15) == 0) period = rand_word();
        jitter = $urandom_range(0, 8);
        ts = cur_stamp + period + jitter - 4;
      end else if (pick < 85) begin
        ts = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: ts = 32'h7FFF_FFFF;
          1: ts = 32'h8000_0000;
          2: ts = cur_stamp ^ 32'h8000_0000;
          default: ts = cur_stamp - 32'h4000_0000 - $urandom_range(0, 255);
        endcase
      end
      send_pair(ts, rand_word());
      cur_stamp = ts;
      random_gap();
    end

    idle_input(1);
    drain_output();
    repeat (DrainCycles) @(posedge clk);

    $display("run covered %0d pairs and %0d bytes, %0d of them restarting the delta chain",
             sb.pairs, sb.bytes_seen, sb.resyncs);
    $display("with extremes, both overflow kinds, a long output hold-off and a full drain");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("delta_of_delta_varint_packer_core: match");
    end else begin
      $display("delta_of_delta_varint_packer_core: mismatch");
    end
    $finish;
  end

endmodule
